/* sv/bblc_pkg.sv */
`timescale 1ns / 1ps

package bblc_pkg;

    localparam int ENTRIES_DEF = 32;
    localparam logic [47:0] BUDGET_RST = 48'd268435456;

    localparam logic [2:0] ACT_PUT      = 3'd0;
    localparam logic [2:0] ACT_GET      = 3'd1;
    localparam logic [2:0] ACT_CONTAINS = 3'd2;
    localparam logic [2:0] ACT_CLEAR    = 3'd3;
    localparam logic [2:0] ACT_RANGE    = 3'd4;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] frame_number;
        logic [31:0]        frame_bytes;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
    } t_req;

    typedef struct packed {
        logic        found;
        logic [4:0]  slot;
        logic [5:0]  evicted_count;
        logic [47:0] total_bytes;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
    } t_rsp;

    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'b0, b};
        return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

    function automatic logic [47:0] floor_sub48(input logic [47:0] a, input logic [31:0] b);
        logic [47:0] bb;
        bb = {16'b0, b};
        return (a > bb) ? (a - bb) : 48'd0;
    endfunction

endpackage

/* sv/byte_budget_lru_cache.sv */
`timescale 1ns / 1ps
// Channel   | Signals                                         | Handshake
// ----------+-------------------------------------------------+---------------------------
// request   | i_action, i_frame_number, i_frame_bytes,        | start & !busy
//           | i_range_low, i_range_high                       |
// result    | o_found, o_slot, o_evicted_count, o_total_bytes,| o_done, one cycle
//           | o_hit_count, o_miss_count                       |
// config    | psel, penable, pwrite, paddr, pwdata, prdata    | psel & penable & pwrite
//
// Every defined action walks the slot table through one shared scan unit and a registered
// table read; each scan issues every slot address, waits for the registered read and drains.
// Contains, get miss and clear take one scan plus the result state; a get hit adds a
// re-rank scan, a put of a held frame adds a byte-update state and a re-rank scan.
// A new put takes the lookup scan, a check state, one oldest-entry scan and check per
// eviction, a slot scan, an insert state and the result state.
// Clearing outside a range takes one scan plus one re-rank scan per removed entry.
// Reset is synchronous: the table is empty, totals and counters are zero.
// busy stays high until the cycle after o_done; the receiver cannot stall.

module byte_budget_lru_cache #(
    parameter int ENTRIES = bblc_pkg::ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_action,
    input  logic signed [31:0] i_frame_number,
    input  logic [31:0]        i_frame_bytes,
    input  logic signed [31:0] i_range_low,
    input  logic signed [31:0] i_range_high,
    output logic               o_done,
    output logic               o_found,
    output logic [4:0]         o_slot,
    output logic [5:0]         o_evicted_count,
    output logic [47:0]        o_total_bytes,
    output logic [31:0]        o_hit_count,
    output logic [31:0]        o_miss_count,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    import bblc_pkg::*;

    logic [47:0] r_budget;
    t_req req;
    t_rsp rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= BUDGET_RST;
        end else if (psel && penable && pwrite) begin
            r_budget <= pwdata[47:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = {16'b0, r_budget};

    assign req.action       = i_action;
    assign req.frame_number = i_frame_number;
    assign req.frame_bytes  = i_frame_bytes;
    assign req.range_low    = i_range_low;
    assign req.range_high   = i_range_high;

    bblc_seq #(.ENTRIES(ENTRIES)) u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_req(req),
        .i_budget(r_budget), .o_busy(busy), .o_done(o_done), .o_rsp(rsp)
    );

    assign o_found         = rsp.found;
    assign o_slot          = rsp.slot;
    assign o_evicted_count = rsp.evicted_count;
    assign o_total_bytes   = rsp.total_bytes;
    assign o_hit_count     = rsp.hit_count;
    assign o_miss_count    = rsp.miss_count;

endmodule

/* sv/bblc_ram.sv */
`timescale 1ns / 1ps

module bblc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* sv/bblc_seq.sv */
`timescale 1ns / 1ps

module bblc_seq #(
    parameter int ENTRIES = bblc_pkg::ENTRIES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  bblc_pkg::t_req i_req,
    input  logic [47:0]    i_budget,
    output logic           o_busy,
    output logic           o_done,
    output bblc_pkg::t_rsp o_rsp
);
    import bblc_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW:0] N_ENT = (IW+1)'(ENTRIES);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_LOOK    = 9'b000000010,
        S_ADDB    = 9'b000000100,
        S_EVCHK   = 9'b000001000,
        S_FINDOLD = 9'b000010000,
        S_ADJ     = 9'b000100000,
        S_INSERT  = 9'b001000000,
        S_RSCAN   = 9'b010000000,
        S_DONE    = 9'b100000000
    } t_state;

    typedef enum logic [2:0] {
        M_INC_ALL   = 3'b001,
        M_INC_BELOW = 3'b010,
        M_DEC_ABOVE = 3'b100
    } t_mode;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    t_req   r_req, n_req;
    logic [IW:0]   r_idx, n_idx, r_n, n_n, r_removed, n_removed, r_cursor, n_cursor;
    logic          r_pv, n_pv, r_found, n_found, r_free_ok, n_free_ok;
    logic [IW-1:0] r_pidx, n_pidx, r_slot, n_slot, r_rank, n_rank;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [31:0]   r_sbytes, n_sbytes, r_hits, n_hits, r_misses, n_misses;
    logic [47:0]   r_held, n_held;

    logic          key_we, bytes_we, age_we;
    logic [IW-1:0] age_waddr, age_wdata;
    logic [31:0]   rd_key, rd_bytes;
    logic [IW-1:0] rd_age;

    logic in_pass, issue, pass_end, cur_v, outside;

    bblc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_key (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(r_slot), .i_wdata(r_req.frame_number),
        .i_raddr(r_idx[IW-1:0]), .o_rdata(rd_key)
    );
    bblc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_bytes (
        .i_clk(i_clk), .i_we(bytes_we), .i_waddr(r_slot), .i_wdata(r_req.frame_bytes),
        .i_raddr(r_idx[IW-1:0]), .o_rdata(rd_bytes)
    );
    bblc_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_age (
        .i_clk(i_clk), .i_we(age_we), .i_waddr(age_waddr), .i_wdata(age_wdata),
        .i_raddr(r_idx[IW-1:0]), .o_rdata(rd_age)
    );

    assign in_pass  = (r_state == S_LOOK) || (r_state == S_FINDOLD) ||
                      (r_state == S_ADJ) || (r_state == S_RSCAN);
    assign issue    = r_idx < N_ENT;
    assign pass_end = (r_idx == N_ENT) && !r_pv;
    assign cur_v    = r_pv && r_valid[r_pidx];
    assign outside  = ($signed(rd_key) < r_req.range_low) ||
                      ($signed(rd_key) > r_req.range_high);

    always_comb begin
        n_state = r_state;  n_mode = r_mode;  n_req = r_req;
        n_idx = r_idx;  n_pv = 1'b0;  n_pidx = r_pidx;
        n_n = r_n;  n_removed = r_removed;  n_cursor = r_cursor;
        n_found = r_found;  n_free_ok = r_free_ok;  n_slot = r_slot;  n_rank = r_rank;
        n_valid = r_valid;  n_sbytes = r_sbytes;  n_hits = r_hits;  n_misses = r_misses;
        n_held = r_held;
        key_we = 1'b0;  bytes_we = 1'b0;  age_we = 1'b0;
        age_waddr = r_pidx;  age_wdata = '0;

        if (in_pass) begin
            n_idx  = issue ? r_idx + 1'b1 : r_idx;
            n_pv   = issue;
            n_pidx = r_idx[IW-1:0];
        end

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req = i_req;  n_removed = '0;  n_n = '0;
                    n_found = 1'b0;  n_slot = '0;  n_idx = '0;  n_pv = 1'b0;
                    case (i_req.action)
                        ACT_PUT, ACT_GET, ACT_CONTAINS, ACT_CLEAR: n_state = S_LOOK;
                        ACT_RANGE: n_state = S_RSCAN;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_LOOK: begin
                if (cur_v) begin
                    n_n = r_n + 1'b1;
                    if (rd_key == r_req.frame_number && !r_found &&
                        r_req.action != ACT_CLEAR) begin
                        n_found = 1'b1;  n_slot = r_pidx;
                        n_rank = rd_age;  n_sbytes = rd_bytes;
                    end
                end
                if (pass_end) begin
                    n_idx = '0;
                    case (r_req.action)
                        ACT_PUT: begin
                            if (r_found) begin
                                n_held = floor_sub48(r_held, r_sbytes);
                                bytes_we = 1'b1;
                                n_state = S_ADDB;
                            end else begin
                                n_state = S_EVCHK;
                            end
                        end
                        ACT_GET: begin
                            if (r_found) begin
                                if (r_hits != 32'hFFFF_FFFF) n_hits = r_hits + 1'b1;
                                n_mode = M_INC_BELOW;
                                n_state = S_ADJ;
                            end else begin
                                if (r_misses != 32'hFFFF_FFFF) n_misses = r_misses + 1'b1;
                                n_state = S_DONE;
                            end
                        end
                        ACT_CLEAR: begin
                            n_valid = '0;  n_held = '0;  n_removed = r_n;
                            n_state = S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_ADDB: begin
                n_held = sat_add48(r_held, r_req.frame_bytes);
                n_mode = M_INC_BELOW;  n_idx = '0;
                n_state = S_ADJ;
            end
            S_EVCHK: begin
                n_idx = '0;
                if (r_n != '0 && (r_n == N_ENT ||
                    sat_add48(r_held, r_req.frame_bytes) > i_budget)) begin
                    n_state = S_FINDOLD;
                end else begin
                    n_mode = M_INC_ALL;  n_free_ok = 1'b0;  n_slot = '0;
                    n_state = S_ADJ;
                end
            end
            S_FINDOLD: begin
                // oldest entry holds the top rank, count minus one
                if (cur_v && rd_age == IW'(r_n - 1'b1)) begin
                    n_slot = r_pidx;  n_sbytes = rd_bytes;
                end
                if (pass_end) begin
                    n_valid[r_slot] = 1'b0;
                    n_held = floor_sub48(r_held, r_sbytes);
                    n_n = r_n - 1'b1;
                    n_removed = r_removed + 1'b1;
                    n_state = S_EVCHK;
                end
            end
            S_ADJ: begin
                if (r_pv) begin
                    case (r_mode)
                        M_INC_ALL: begin
                            if (r_valid[r_pidx]) begin
                                age_we = 1'b1;  age_wdata = rd_age + 1'b1;
                            end else if (!r_free_ok) begin
                                n_free_ok = 1'b1;  n_slot = r_pidx;
                            end
                        end
                        M_INC_BELOW: begin
                            if (r_pidx == r_slot) begin
                                age_we = 1'b1;  age_wdata = '0;
                            end else if (r_valid[r_pidx] && rd_age < r_rank) begin
                                age_we = 1'b1;  age_wdata = rd_age + 1'b1;
                            end
                        end
                        M_DEC_ABOVE: begin
                            if (r_valid[r_pidx] && rd_age > r_rank) begin
                                age_we = 1'b1;  age_wdata = rd_age - 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                if (pass_end) begin
                    case (r_mode)
                        M_INC_ALL:   n_state = S_INSERT;
                        M_DEC_ABOVE: begin
                            n_idx = r_cursor;
                            n_state = S_RSCAN;
                        end
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_INSERT: begin
                key_we = 1'b1;  bytes_we = 1'b1;
                age_we = 1'b1;  age_waddr = r_slot;  age_wdata = '0;
                n_valid[r_slot] = 1'b1;
                n_held = sat_add48(r_held, r_req.frame_bytes);
                n_state = S_DONE;
            end
            S_RSCAN: begin
                if (cur_v && outside) begin
                    // drop the entry, re-rank survivors, then resume after it
                    n_valid[r_pidx] = 1'b0;
                    n_held = floor_sub48(r_held, rd_bytes);
                    n_removed = r_removed + 1'b1;
                    n_rank = rd_age;
                    n_cursor = {1'b0, r_pidx} + 1'b1;
                    n_mode = M_DEC_ABOVE;
                    n_idx = '0;  n_pv = 1'b0;
                    n_state = S_ADJ;
                end else if (pass_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pv     <= 1'b0;
            r_valid  <= '0;
            r_held   <= '0;
            r_hits   <= '0;
            r_misses <= '0;
        end else begin
            r_state  <= n_state;
            r_pv     <= n_pv;
            r_valid  <= n_valid;
            r_held   <= n_held;
            r_hits   <= n_hits;
            r_misses <= n_misses;
        end
        r_mode <= n_mode;  r_req <= n_req;  r_idx <= n_idx;  r_pidx <= n_pidx;
        r_n <= n_n;  r_removed <= n_removed;  r_cursor <= n_cursor;
        r_found <= n_found;  r_free_ok <= n_free_ok;  r_slot <= n_slot;
        r_rank <= n_rank;  r_sbytes <= n_sbytes;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_rsp.found         = r_found;
    assign o_rsp.slot          = 5'(r_slot);
    assign o_rsp.evicted_count = 6'(r_removed);
    assign o_rsp.total_bytes   = r_held;
    assign o_rsp.hit_count     = r_hits;
    assign o_rsp.miss_count    = r_misses;

endmodule

/* sv/bblc_chk.sv */
`timescale 1ns / 1ps

module bblc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic        pready,
    input logic [31:0] o_hit_count,
    input logic [31:0] o_miss_count
);

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("result strobe while idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("request accepted but not busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!o_done && !busy)) else $error("result strobe not a single pulse");

    a_hits_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (o_hit_count >= $past(o_hit_count) &&
                            o_miss_count >= $past(o_miss_count)))
        else $error("hit or miss counter went down");

    a_pready: assert property (@(posedge i_clk) pready) else $error("pready low");

endmodule

bind byte_budget_lru_cache bblc_chk u_chk (.*);
